>>> design/sps_pkg.sv
// sps_pkg: shared constants, widths and types of the seeded permutation shuffle
// depends on nothing; used by sps_mod and seeded_permutation_shuffle_top
package sps_pkg;

   // deck size default and fixed field widths
   localparam int DECK_SIZE_DEF = 64;
   localparam int SEED_W        = 32;
   localparam int CNT_W         = 7;
   localparam int OUT_W         = 6;

   // linear congruential generator
   localparam logic [SEED_W-1:0] LCG_MUL = 32'd1103515245;
   localparam logic [SEED_W-1:0] LCG_ADD = 32'd12345;
   localparam logic [SEED_W-1:0] LCG_RST = 32'd1;
   localparam int DRAW_LSB = 16;
   localparam int DRAW_W   = 15;

   // remainder unit: two quotient bits per cycle
   localparam int MOD_ITERS = (DRAW_W + 1) / 2;
   localparam int MOD_PAD_W = 2 * MOD_ITERS;
   localparam int MOD_CNT_W = $clog2(MOD_ITERS + 1);

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_DRAW,
      ST_MOD,
      ST_READ,
      ST_SWAP_I,
      ST_SWAP_R,
      ST_EMIT
   } sps_state_type;

endpackage

>>> design/sps_mod.sv
// sps_mod: iterative remainder unit, draw mod bound, two bits per cycle
// depends on sps_pkg
module sps_mod
   import sps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DRAW_W-1:0] dividend,
   input  logic [CNT_W-1:0]  divisor,
   output logic              busy,
   output logic              done,
   output logic [CNT_W-1:0]  remainder
);

   logic [MOD_PAD_W-1:0] dvd_ff, dvd_in;
   logic [CNT_W-1:0]     dsr_ff, dsr_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;

   logic [CNT_W:0]   t1, t2, s1, s2, dext;
   logic [CNT_W-1:0] r1, r2;

   // two restoring steps on the partial remainder
   always_comb begin
      dext = {1'b0, dsr_ff};
      t1   = {rem_ff, dvd_ff[MOD_PAD_W-1]};
      s1   = t1 - dext;
      r1   = (t1 >= dext) ? s1[CNT_W-1:0] : t1[CNT_W-1:0];
      t2   = {r1, dvd_ff[MOD_PAD_W-2]};
      s2   = t2 - dext;
      r2   = (t2 >= dext) ? s2[CNT_W-1:0] : t2[CNT_W-1:0];
   end

   // load on start, then iterate until the counter runs out
   always_comb begin
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in = MOD_PAD_W'(dividend);
         dsr_in = divisor;
         rem_in = '0;
         cnt_in = MOD_CNT_W'(MOD_ITERS);
      end else if (cnt_ff != '0) begin
         dvd_in  = dvd_ff << 2;
         rem_in  = r2;
         cnt_in  = cnt_ff - MOD_CNT_W'(1);
         done_in = (cnt_ff == MOD_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign busy      = (cnt_ff != '0);
   assign done      = done_ff;
   assign remainder = rem_ff;

   // checks
   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      start |-> !busy) else $error("remainder unit restarted while busy");
   a_done_after_last : assert property (@(posedge clock) disable iff (reset)
      done |-> ($past(cnt_ff) == MOD_CNT_W'(1)))
      else $error("done without a final iteration");
   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      (done && dsr_ff != '0) |-> (rem_ff < dsr_ff))
      else $error("remainder not below divisor");

endmodule

>>> design/seeded_permutation_shuffle_top.sv
// seeded_permutation_shuffle_top: sequencer, generator and deck memory
// depends on sps_pkg and sps_mod
//
// One transaction (req_seed, req_count) is taken when start is high and busy
// is low. The count saturates to DECK_SIZE; a zero count gives no result.
// The deck memory is first written with the identity over n entries, then
// each shuffle position i from n-1 down to 1 takes one generator step (a
// 32x32 multiply), a pass through the remainder unit (two bits a cycle over
// the 15-bit draw), a read and a two-write swap on the single write port
// of the deck memory. Results then leave one a cycle, each on rsp_position,
// rsp_card and rsp_last for one cycle with rsp_valid high; the receiver
// cannot hold them off. The last result of an item is on the ports in the
// first cycle with busy low again.
module seeded_permutation_shuffle_top
   import sps_pkg::*;
#(
   parameter int DECK_SIZE = DECK_SIZE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [SEED_W-1:0] req_seed,
   input  logic [CNT_W-1:0]  req_count,
   output logic              rsp_valid,
   output logic [OUT_W-1:0]  rsp_position,
   output logic [OUT_W-1:0]  rsp_card,
   output logic              rsp_last
);

   localparam int IDX_W   = $clog2(DECK_SIZE);
   localparam int CNT_MAX = (1 << CNT_W) - 1;
   localparam int SAT_N   = (DECK_SIZE < CNT_MAX) ? DECK_SIZE : CNT_MAX;

   sps_state_type state_ff, state_in;

   logic [CNT_W-1:0]  n_ff, n_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  r_ff, r_in;
   logic [SEED_W-1:0] lcg_ff, lcg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic [CNT_W-1:0]  n_sat;
   logic [IDX_W-1:0]  last_idx;
   logic [SEED_W-1:0] lcg_next;

   // deck memory and its ports
   logic [IDX_W-1:0] deck_mem [DECK_SIZE];
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr, mem_wdata;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr_a, rd_addr_b;
   logic [IDX_W-1:0] rd_a_ff, rd_b_ff;

   // remainder unit
   logic              mod_start, mod_busy, mod_done;
   logic [CNT_W-1:0]  mod_divisor, mod_rem;
   logic [DRAW_W-1:0] mod_dividend;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign n_sat    = (req_count > CNT_W'(SAT_N)) ? CNT_W'(SAT_N) : req_count;
   assign last_idx = IDX_W'(n_ff - CNT_W'(1));
   assign lcg_next = lcg_ff * LCG_MUL + LCG_ADD;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && n_sat != '0) state_in = ST_INIT;
         end
         ST_INIT: begin
            if (ptr_ff == last_idx) state_in = (last_idx == '0) ? ST_EMIT : ST_DRAW;
         end
         ST_DRAW: state_in = ST_MOD;
         ST_MOD: begin
            if (mod_done) state_in = ST_READ;
         end
         ST_READ:   state_in = ST_SWAP_I;
         ST_SWAP_I: state_in = ST_SWAP_R;
         ST_SWAP_R: state_in = (i_ff == IDX_W'(1)) ? ST_EMIT : ST_DRAW;
         ST_EMIT: begin
            if (ptr_ff == last_idx) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory and remainder unit control
   always_comb begin
      mem_we       = 1'b0;
      mem_waddr    = ptr_ff;
      mem_wdata    = ptr_ff;
      rd_en        = 1'b0;
      rd_addr_a    = i_ff;
      rd_addr_b    = r_ff;
      mod_start    = 1'b0;
      mod_dividend = lcg_next[DRAW_LSB +: DRAW_W];
      mod_divisor  = CNT_W'(i_ff) + CNT_W'(1);
      unique case (state_ff)
         ST_INIT: mem_we = 1'b1;
         ST_DRAW: mod_start = 1'b1;
         ST_READ: rd_en = 1'b1;
         ST_SWAP_I: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = rd_b_ff;
         end
         ST_SWAP_R: begin
            mem_we    = 1'b1;
            mem_waddr = r_ff;
            mem_wdata = rd_a_ff;
         end
         ST_EMIT: begin
            rd_en     = 1'b1;
            rd_addr_a = ptr_ff;
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      n_in         = n_ff;
      ptr_in       = ptr_ff;
      i_in         = i_ff;
      r_in         = r_ff;
      lcg_in       = lcg_ff;
      rsp_valid_in = 1'b0;
      rsp_pos_in   = OUT_W'(ptr_ff);
      rsp_last_in  = (ptr_ff == last_idx);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               n_in   = n_sat;
               lcg_in = req_seed;
               ptr_in = '0;
            end
         end
         ST_INIT: begin
            if (ptr_ff == last_idx) begin
               i_in   = last_idx;
               ptr_in = '0;
            end else begin
               ptr_in = ptr_ff + IDX_W'(1);
            end
         end
         ST_DRAW: lcg_in = lcg_next;
         ST_MOD: begin
            if (mod_done) r_in = IDX_W'(mod_rem);
         end
         ST_SWAP_R: i_in = i_ff - IDX_W'(1);
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            ptr_in       = ptr_ff + IDX_W'(1);
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lcg_ff       <= LCG_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lcg_ff       <= lcg_in;
      end
      n_ff        <= n_in;
      ptr_ff      <= ptr_in;
      i_ff        <= i_in;
      r_ff        <= r_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
   end

   // deck memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) deck_mem[mem_waddr] <= mem_wdata;
      if (rd_en) begin
         rd_a_ff <= deck_mem[rd_addr_a];
         rd_b_ff <= deck_mem[rd_addr_b];
      end
   end

   sps_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (mod_divisor),
      .busy      (mod_busy),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // result outputs
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_card     = OUT_W'(rd_a_ff);
   assign rsp_last     = rsp_last_ff;

   // checks
   a_rsp_from_emit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EMIT))
      else $error("result without an emit cycle");
   a_mod_in_wait : assert property (@(posedge clock) disable iff (reset)
      (mod_done || mod_busy) |-> (state_ff == ST_MOD))
      else $error("remainder unit active outside its wait state");
   a_partner_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (r_ff <= i_ff))
      else $error("swap partner above current position");
   a_accept_init : assert property (@(posedge clock) disable iff (reset)
      (accept && req_count != '0) |=> (state_ff == ST_INIT))
      else $error("accepted transaction did not start the identity fill");

endmodule

>>> test/seeded_permutation_shuffle_top_test.sv
// seeded_permutation_shuffle_top_test: self-checking bench for the seeded deck shuffle
// depends on sps_pkg and seeded_permutation_shuffle_top; predicts every dealt card itself
// directed table of seeds and counts first, then random transactions with random gaps
module seeded_permutation_shuffle_top_test
   import sps_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // bench constants
   localparam int          DECK_DEPTH   = 64;
   localparam logic [31:0] GEN_MULT     = 32'd1103515245;
   localparam logic [31:0] GEN_INCR     = 32'd12345;
   localparam int          RANDOM_ITEMS = 240;
   localparam int          TAIL_CYCLES  = 1100;
   localparam int          CYCLE_LIMIT  = 1500000;
   localparam int          PLAN_ROWS    = 20;

   // one dealt card as seen on the result ports
   typedef struct packed {
      logic [OUT_W-1:0] position;
      logic [OUT_W-1:0] card;
      logic             last;
   } dealt_card_type;

   // one row of the directed plan; typed rows carry their obvious outcome
   typedef struct packed {
      logic [SEED_W-1:0] seed;
      logic [CNT_W-1:0]  count;
      logic              typed;
      logic [OUT_W-1:0]  typed_card;
   } plan_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [SEED_W-1:0] req_seed;
   logic [CNT_W-1:0]  req_count;
   logic              rsp_valid;
   logic [OUT_W-1:0]  rsp_position;
   logic [OUT_W-1:0]  rsp_card;
   logic              rsp_last;

   dealt_card_type expected_cards[$];
   int          mismatch_count = 0;
   int          cards_checked  = 0;
   int          shuffles_sent  = 0;
   int          empty_shuffles = 0;
   int          capped_shuffles = 0;
   int          cycle_count    = 0;

   // directed plan: extremes of seed and count, saturation and zero count
   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{32'h0000_0000, 7'd1,   1'b1, 6'd0},
      '{32'hffff_ffff, 7'd1,   1'b1, 6'd0},
      '{32'h0000_0000, 7'd0,   1'b1, 6'd0},
      '{32'hffff_ffff, 7'd0,   1'b1, 6'd0},
      '{32'h8000_0000, 7'd1,   1'b1, 6'd0},
      '{32'h0000_0001, 7'd2,   1'b0, 6'd0},
      '{32'h0000_0000, 7'd2,   1'b0, 6'd0},
      '{32'hffff_ffff, 7'd2,   1'b0, 6'd0},
      '{32'h0000_0000, 7'd64,  1'b0, 6'd0},
      '{32'hffff_ffff, 7'd64,  1'b0, 6'd0},
      '{32'h1234_5678, 7'd65,  1'b0, 6'd0},
      '{32'ha5a5_a5a5, 7'd127, 1'b0, 6'd0},
      '{32'h5a5a_5a5a, 7'd96,  1'b0, 6'd0},
      '{32'h0000_0001, 7'd63,  1'b0, 6'd0},
      '{32'h8000_0000, 7'd3,   1'b0, 6'd0},
      '{32'h7fff_ffff, 7'd33,  1'b0, 6'd0},
      '{32'hdead_beef, 7'd16,  1'b0, 6'd0},
      '{32'h1357_9bdf, 7'd0,   1'b1, 6'd0},
      '{32'h2468_ace0, 7'd5,   1'b0, 6'd0},
      '{32'hc0ff_ee00, 7'd8,   1'b0, 6'd0}
   };

   seeded_permutation_shuffle_top #(
      .DECK_SIZE(DECK_DEPTH)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_seed     (req_seed),
      .req_count    (req_count),
      .rsp_valid    (rsp_valid),
      .rsp_position (rsp_position),
      .rsp_card     (rsp_card),
      .rsp_last     (rsp_last)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // shuffle predictor: queues the dealt cards of one transaction
   function automatic void predict_shuffle(input logic [SEED_W-1:0] seed,
                                           input logic [CNT_W-1:0] count);
      logic [31:0]      gen;
      logic [OUT_W-1:0] deck [DECK_DEPTH];
      logic [OUT_W-1:0] held;
      int unsigned      n;
      int unsigned      draw;
      int unsigned      partner;
      dealt_card_type   dealt;
      n   = (count > DECK_DEPTH) ? DECK_DEPTH : count;
      gen = seed;
      for (int k = 0; k < DECK_DEPTH; k++) begin
         deck[k] = OUT_W'(k);
      end
      // backward walk, no draw at position zero
      for (int i = int'(n) - 1; i > 0; i--) begin
         gen     = gen * GEN_MULT + GEN_INCR;
         draw    = gen[30:16];
         partner = draw % (i + 1);
         held          = deck[i];
         deck[i]       = deck[partner];
         deck[partner] = held;
      end
      for (int i = 0; i < int'(n); i++) begin
         dealt.position = OUT_W'(i);
         dealt.card     = deck[i];
         dealt.last     = (i == int'(n) - 1);
         expected_cards.push_back(dealt);
      end
   endfunction

   // mismatch reporting
   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // send one transaction after an idle gap, then queue what it should deal
   task automatic issue_shuffle(input logic [SEED_W-1:0] seed, input logic [CNT_W-1:0] count,
                                input int gap, input logic typed,
                                input logic [OUT_W-1:0] typed_card);
      dealt_card_type dealt;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_seed  <= seed;
      req_count <= count;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      // transaction taken at this edge
      if (typed) begin
         if (count != 0) begin
            dealt.position = '0;
            dealt.card     = typed_card;
            dealt.last     = 1'b1;
            expected_cards.push_back(dealt);
         end
      end else begin
         predict_shuffle(seed, count);
      end
      shuffles_sent++;
      if (count == 0) empty_shuffles++;
      if (count > DECK_DEPTH) capped_shuffles++;
   endtask

   // hold off until every queued card has come out
   task automatic drain_cards();
      start <= 1'b0;
      @(posedge clock);
      while (expected_cards.size() != 0) @(posedge clock);
   endtask

   // result checking against the oldest queued card
   always @(posedge clock) begin
      dealt_card_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_cards.size() == 0) begin
            report_mismatch("unexpected card at position", rsp_position, -1);
         end else begin
            want = expected_cards.pop_front();
            cards_checked++;
            if (rsp_position !== want.position)
               report_mismatch("position", rsp_position, want.position);
            if (rsp_card !== want.card)
               report_mismatch("card", rsp_card, want.card);
            if (rsp_last !== want.last)
               report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[seeded_permutation_shuffle_top] ERROR");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      logic [SEED_W-1:0] seed;
      logic [CNT_W-1:0]  count;
      int                gap;
      int                pick;
      reset     = 1'b1;
      start     = 1'b0;
      req_seed  = '0;
      req_count = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_plan[k]) begin
         issue_shuffle(directed_plan[k].seed, directed_plan[k].count,
                       (k % 3 == 0) ? 0 : $urandom_range(0, 9),
                       directed_plan[k].typed, directed_plan[k].typed_card);
      end
      drain_cards();

      // random transactions, bursts without gaps every third stretch
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 4)       count = '0;
         else if (pick < 12) count = CNT_W'($urandom_range(64, 127));
         else if (pick < 24) count = CNT_W'($urandom_range(13, 64));
         else                count = CNT_W'($urandom_range(1, 12));
         pick = $urandom_range(0, 9);
         if (pick == 0)      seed = '0;
         else if (pick == 1) seed = '1;
         else if (pick == 2) seed = 32'h1 << $urandom_range(0, 31);
         else                seed = $urandom;
         gap = ((k / 20) % 3 == 0) ? 0 : $urandom_range(0, 9);
         issue_shuffle(seed, count, gap, 1'b0, '0);
         if (k == RANDOM_ITEMS / 2) drain_cards();
      end
      start <= 1'b0;

      // wait out the last cards and watch for stray ones
      while (expected_cards.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d shuffles (%0d empty, %0d over deck size), %0d cards checked",
               shuffles_sent, empty_shuffles, capped_shuffles, cards_checked);
      $display("seeds at both extremes, counts from 0 to 127, gaps of 0 to 9 cycles");
      if (mismatch_count == 0) begin
         $display("[seeded_permutation_shuffle_top] OK");
      end else begin
         $display("[seeded_permutation_shuffle_top] ERROR");
      end
      $finish;
   end

endmodule
